>>> hdl/assert_macros.svh
// Assertion macros used by the positioner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ALSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alsp: implication check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ALSP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alsp: next-cycle check failed");
`else
`define ALSP_ASSERT_IMP(label, ante, cons)
`define ALSP_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hdl/alsp_pkg.sv
// Package: codes, reset constants and shared types of the arm positioner.
`default_nettype none
package alsp_pkg;

	// Arm modes (also the reported arm_state)
	localparam logic [2:0] MODE_STOPPED = 3'd0;
	localparam logic [2:0] MODE_BOTTOM  = 3'd1;
	localparam logic [2:0] MODE_STORE   = 3'd2;
	localparam logic [2:0] MODE_TOP     = 3'd3;
	localparam logic [2:0] MODE_UP      = 3'd4;
	localparam logic [2:0] MODE_DOWN    = 3'd5;
	localparam logic [2:0] TARGET_NONE  = 3'd7;
	localparam logic [2:0] GOAL_REACHED = 3'd7;

	// Operator requests
	localparam logic [2:0] REQ_NONE   = 3'd0;
	localparam logic [2:0] REQ_UP     = 3'd1;
	localparam logic [2:0] REQ_DOWN   = 3'd2;
	localparam logic [2:0] REQ_STOP   = 3'd3;
	localparam logic [2:0] REQ_TOP    = 3'd4;
	localparam logic [2:0] REQ_STORE  = 3'd5;
	localparam logic [2:0] REQ_BOTTOM = 3'd6;

	// Side of the store switch
	localparam logic [1:0] SIDE_AT    = 2'd0;
	localparam logic [1:0] SIDE_ABOVE = 2'd1;
	localparam logic [1:0] SIDE_BELOW = 2'd2;

	// Travel direction
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Dead band around stop_speed for direction sensing
	localparam logic [8:0] DIR_BAND = 9'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_UP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DOWN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_UP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DOWN = 3'd4;

	// Configuration reset values
	localparam logic [7:0] RST_STOP_SPEED      = 8'd127;
	localparam logic [7:0] RST_FULL_UP_SPEED   = 8'd255;
	localparam logic [7:0] RST_FULL_DOWN_SPEED = 8'd0;
	localparam logic [7:0] RST_SLOW_UP_SPEED   = 8'd180;
	localparam logic [7:0] RST_SLOW_DOWN_SPEED = 8'd75;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef struct packed {
		logic [7:0] stop_speed;
		logic [7:0] full_up_speed;
		logic [7:0] full_down_speed;
		logic [7:0] slow_up_speed;
		logic [7:0] slow_down_speed;
	} alsp_speeds_t;

	typedef struct packed {
		logic [2:0] request;
		logic       top_limit;
		logic       middle_limit;
		logic       bottom_limit;
		logic       wrist_raised;
	} alsp_item_t;

	typedef struct packed {
		logic [2:0] current_mode;
		logic [2:0] target_mode;
		logic [2:0] goal_pending;
		logic [1:0] side_of_store;
		logic [1:0] travel_direction;
		logic [7:0] motor_level;
		logic       brake_on;
		logic       up_slow;
		logic       down_slow;
	} alsp_state_t;

endpackage
`default_nettype wire

>>> hdl/alsp_tick.sv
// Next-state logic for one control tick: request handling, then sensor rules.
`default_nettype none
module alsp_tick (
	input  alsp_pkg::alsp_state_t  cur,
	input  alsp_pkg::alsp_item_t   item,
	input  alsp_pkg::alsp_speeds_t speeds,
	output alsp_pkg::alsp_state_t  nxt
);
	import alsp_pkg::*;

	function automatic alsp_state_t go_mode(input alsp_state_t s, input logic [2:0] m,
			input alsp_speeds_t spd);
		alsp_state_t r;
		r = s;
		case (m) inside
			MODE_STOPPED, MODE_BOTTOM, MODE_STORE, MODE_TOP: begin
				r.brake_on     = 1'b1;
				r.motor_level  = spd.stop_speed;
				r.current_mode = m;
			end
			MODE_UP: begin
				r.brake_on     = 1'b0;
				r.motor_level  = s.up_slow ? spd.slow_up_speed : spd.full_up_speed;
				r.current_mode = MODE_UP;
			end
			MODE_DOWN: begin
				r.brake_on     = 1'b0;
				r.motor_level  = s.down_slow ? spd.slow_down_speed : spd.full_down_speed;
				r.current_mode = MODE_DOWN;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	alsp_state_t st;
	logic [2:0]  c;
	logic [8:0]  lvl_ext;
	logic [8:0]  stp_ext;

	always_comb begin
		st      = cur;
		c       = cur.current_mode;
		lvl_ext = {1'b0, cur.motor_level};
		stp_ext = {1'b0, speeds.stop_speed};

		// request, ignored while the wrist is raised
		if (!item.wrist_raised) begin
			unique case (item.request)
				REQ_BOTTOM: begin
					st.target_mode  = MODE_BOTTOM;
					st.goal_pending = MODE_BOTTOM;
					if (c inside {MODE_UP, MODE_STOPPED, MODE_STORE, MODE_TOP})
						st = go_mode(st, MODE_DOWN, speeds);
				end
				REQ_TOP: begin
					st.target_mode  = MODE_TOP;
					st.goal_pending = MODE_TOP;
					if (c inside {MODE_STOPPED, MODE_BOTTOM, MODE_DOWN, MODE_STORE})
						st = go_mode(st, MODE_UP, speeds);
				end
				REQ_STORE: begin
					st.target_mode  = MODE_STORE;
					st.goal_pending = MODE_STORE;
					if (c == MODE_BOTTOM)
						st = go_mode(st, MODE_UP, speeds);
					else if (c == MODE_TOP)
						st = go_mode(st, MODE_DOWN, speeds);
					else if (c inside {MODE_UP, MODE_DOWN, MODE_STOPPED}) begin
						if (cur.side_of_store == SIDE_ABOVE)
							st = go_mode(st, MODE_DOWN, speeds);
						else if (cur.side_of_store == SIDE_BELOW)
							st = go_mode(st, MODE_UP, speeds);
					end
				end
				REQ_STOP: begin
					// stop is locked out while a positional goal is pending
					if (cur.goal_pending == GOAL_REACHED) begin
						st.target_mode  = MODE_STOPPED;
						st.goal_pending = GOAL_REACHED;
						if (c inside {MODE_UP, MODE_DOWN})
							st = go_mode(st, MODE_STOPPED, speeds);
					end
				end
				REQ_UP: begin
					st.target_mode  = MODE_UP;
					st.goal_pending = GOAL_REACHED;
					if (c inside {MODE_STOPPED, MODE_DOWN, MODE_BOTTOM, MODE_STORE})
						st = go_mode(st, MODE_UP, speeds);
				end
				REQ_DOWN: begin
					st.target_mode  = MODE_DOWN;
					st.goal_pending = GOAL_REACHED;
					if (c inside {MODE_STOPPED, MODE_UP, MODE_TOP, MODE_STORE})
						st = go_mode(st, MODE_DOWN, speeds);
				end
				default: ;
			endcase
		end

		// sensor rules
		st.up_slow   = 1'b0;
		st.down_slow = 1'b0;
		lvl_ext      = {1'b0, st.motor_level};

		if (lvl_ext > stp_ext + DIR_BAND)
			st.travel_direction = DIR_UP;
		else if (lvl_ext + DIR_BAND < stp_ext)
			st.travel_direction = DIR_DOWN;

		if (st.travel_direction == DIR_UP && item.middle_limit)
			st.side_of_store = SIDE_ABOVE;
		else if (st.travel_direction == DIR_DOWN && item.middle_limit)
			st.side_of_store = SIDE_BELOW;

		if (st.target_mode == MODE_STORE) begin
			if (item.middle_limit)
				st = go_mode(st, MODE_STORE, speeds);
			// overshoot: creep back at slow speed
			if (!item.middle_limit && st.current_mode == MODE_STORE && !item.wrist_raised) begin
				if (st.side_of_store == SIDE_ABOVE) begin
					st.down_slow = 1'b1;
					st = go_mode(st, MODE_DOWN, speeds);
				end else if (st.side_of_store == SIDE_BELOW) begin
					st.up_slow = 1'b1;
					st = go_mode(st, MODE_UP, speeds);
				end
			end
		end

		if (item.top_limit && (st.target_mode == MODE_TOP || st.current_mode == MODE_UP)) begin
			st.side_of_store = SIDE_ABOVE;
			st = go_mode(st, MODE_TOP, speeds);
		end
		if (item.bottom_limit &&
				(st.target_mode == MODE_BOTTOM || st.current_mode == MODE_DOWN)) begin
			st.side_of_store = SIDE_BELOW;
			st = go_mode(st, MODE_BOTTOM, speeds);
		end
	end

	assign nxt = st;

endmodule
`default_nettype wire

>>> hdl/arm_limit_switch_positioner.sv
// Top level: arm positioner with limit-switch rules, stream in/out and config port.
//
// Usage:
//  - s_axis carries one control tick per transaction: operator request, the
//    top/middle/bottom limit switches and the wrist-raised flag.
//  - m_axis returns one transaction per tick: motor PWM command, brake, arm
//    state and side of the store switch.
//  - cfg_* writes the five speed registers (stop, full up, full down, slow up,
//    slow down); always ready, out-of-range indexes are dropped. Write only
//    while no tick is in flight.
//  - Result path: an accepted tick lands in the input register, then its
//    result is loaded, once m_axis is free, into the arm state register
//    that feeds m_axis.
//  - Throughput: one tick per cycle unless m_axis stalls; the state update is a
//    single pass of logic from the input register into the state register.
//  - Receiver stall: the result stays on m_axis, one more tick is held in
//    the input register, then s_axis_tready drops until m_axis drains.
//  - Reset (arst_n low): speeds return to defaults, the arm is stopped with
//    the brake engaged at the stop command, no goal pending, at store.
`default_nettype none
`include "assert_macros.svh"
module arm_limit_switch_positioner (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input ticks
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [2:0] request, [3] top_limit, [4] middle_limit, [5] bottom_limit,
	// [6] wrist_raised, [7] zero
	input  wire  [alsp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// results
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// [7:0] motor_command, [8] brake_engaged, [11:9] arm_state,
	// [13:12] store_side, [15:14] zero
	output logic [alsp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// configuration writes
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [alsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [7:0]                           cfg_data
);
	import alsp_pkg::*;

	alsp_speeds_t speeds_q;
	alsp_item_t   item_s1;
	logic         in_valid_s1;
	alsp_state_t  st_q;
	alsp_state_t  st_next;
	logic         out_valid_q;
	logic         advance;

	// speed registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speeds_q.stop_speed      <= RST_STOP_SPEED;
			speeds_q.full_up_speed   <= RST_FULL_UP_SPEED;
			speeds_q.full_down_speed <= RST_FULL_DOWN_SPEED;
			speeds_q.slow_up_speed   <= RST_SLOW_UP_SPEED;
			speeds_q.slow_down_speed <= RST_SLOW_DOWN_SPEED;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STOP:      speeds_q.stop_speed      <= cfg_data;
				CFG_FULL_UP:   speeds_q.full_up_speed   <= cfg_data;
				CFG_FULL_DOWN: speeds_q.full_down_speed <= cfg_data;
				CFG_SLOW_UP:   speeds_q.slow_up_speed   <= cfg_data;
				CFG_SLOW_DOWN: speeds_q.slow_down_speed <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: the state register doubles as the output register, so
	// it may only advance when m_axis is empty or being drained
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// tick payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.request      <= s_axis_tdata[2:0];
			item_s1.top_limit    <= s_axis_tdata[3];
			item_s1.middle_limit <= s_axis_tdata[4];
			item_s1.bottom_limit <= s_axis_tdata[5];
			item_s1.wrist_raised <= s_axis_tdata[6];
		end
	end

	alsp_tick u_tick (
		.cur    (st_q),
		.item   (item_s1),
		.speeds (speeds_q),
		.nxt    (st_next)
	);

	// arm state, also the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.current_mode     <= MODE_STOPPED;
			st_q.target_mode      <= TARGET_NONE;
			st_q.goal_pending     <= GOAL_REACHED;
			st_q.side_of_store    <= SIDE_AT;
			st_q.travel_direction <= DIR_NONE;
			st_q.motor_level      <= RST_STOP_SPEED;
			st_q.brake_on         <= 1'b1;
			st_q.up_slow          <= 1'b0;
			st_q.down_slow        <= 1'b0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, st_q.side_of_store, st_q.current_mode, st_q.brake_on,
		st_q.motor_level};

	// checks
	`ALSP_ASSERT_IMP(a_brake_matches_mode, out_valid_q, st_q.brake_on == (st_q.current_mode < MODE_UP))
	`ALSP_ASSERT_NXT(a_tick_held_on_stall, in_valid_s1 && out_valid_q && !m_axis_tready, in_valid_s1)
	`ALSP_ASSERT_IMP(a_ready_when_drained, !out_valid_q, s_axis_tready)
	`ALSP_ASSERT_IMP(a_one_creep_dir, 1'b1, !(st_q.up_slow && st_q.down_slow))

endmodule
`default_nettype wire
